/* sv/spb_pkg.sv */
`timescale 1ns / 1ps
package spb_pkg;

  localparam int RX_DEPTH = 1024;
  localparam int TX_DEPTH = 32;

  localparam int RX_AW   = $clog2(RX_DEPTH);
  localparam int FILL_W  = $clog2(RX_DEPTH + 1);
  localparam int TX_AW   = $clog2(TX_DEPTH);
  localparam int TX_PW   = $clog2(TX_DEPTH + 1);

  localparam int BYTE_W  = 8;
  localparam int ENTRY_W = BYTE_W + 1;
  localparam int COUNT_W = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [ENTRY_W-1:0] END_MARK  = ENTRY_W'(9'h100);

  typedef enum logic [1:0] {
    CMD_RX_BYTE    = 2'd0,
    CMD_CS_RELEASE = 2'd1,
    CMD_HOST_POP   = 2'd2,
    CMD_HOST_TX    = 2'd3
  } cmd_t;

endpackage

/* sv/spb_if.sv */
`timescale 1ns / 1ps
interface spb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data;
  logic       message_start;

  modport source (output valid, command, data, message_start, input ready);
  modport sink   (input valid, command, data, message_start, output ready);
endinterface

interface spb_rsp_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_data;
  logic        rd_valid;
  logic [7:0]  rd_data;
  logic        rd_end;
  logic        dropped;
  logic [10:0] packets_pending;
  logic [10:0] ring_used;

  modport source (output valid, tx_valid, tx_data, rd_valid, rd_data, rd_end, dropped,
                  packets_pending, ring_used, input ready);
  modport sink   (input valid, tx_valid, tx_data, rd_valid, rd_data, rd_end, dropped,
                  packets_pending, ring_used, output ready);
endinterface

/* sv/spi_slave_packet_buffer_top.sv */
`timescale 1ns / 1ps
// Packet buffer for an SPI slave.
// Channel req carries one request: command (byte received, chip select released,
// host pop, host transmit byte), data and message_start. Channel rsp returns
// exactly one result per request: the byte handed to the transmit shift
// register, the popped entry with its end flag, a drop flag, and the packet
// count and ring fill after the request.
// Received bytes and end markers sit in a 1024 x 9 ring memory; transmit bytes
// sit in a 32 x 8 queue memory. Both memories have registered reads.
// Each request passes through two steps: accept and read the memories at the
// current pointers, then update pointers and write back. A new request is
// accepted only after the previous one is written back, once the result register frees.
// The result is registered at the update step and stays valid until rsp
// takes it.
// When rsp stalls, the result stays in its register; one further request is
// accepted and held in the update stage until the register frees.
// Reset clears pointers, fill, packet count and the transmit queue position;
// memory contents are left as they are and never read before written.
module spi_slave_packet_buffer_top (
  input  logic      clk,
  input  logic      rst,
  spb_req_if.sink   req,
  spb_rsp_if.source rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;

  logic [spb_pkg::ENTRY_W-1:0] rx_ring [spb_pkg::RX_DEPTH];
  logic [spb_pkg::BYTE_W-1:0]  tx_store [spb_pkg::TX_DEPTH];

  logic [spb_pkg::ENTRY_W-1:0] ring_rdata;
  logic [spb_pkg::BYTE_W-1:0]  tx_rdata;

  logic [spb_pkg::RX_AW-1:0]   rx_write_ptr, rx_write_ptr_next;
  logic [spb_pkg::RX_AW-1:0]   rx_read_ptr, rx_read_ptr_next;
  logic [spb_pkg::FILL_W-1:0]  rx_fill, rx_fill_next;
  logic [spb_pkg::COUNT_W-1:0] packet_count, packet_count_next;
  logic [spb_pkg::TX_PW-1:0]   tx_read_pos, tx_read_pos_next;
  logic [spb_pkg::TX_PW-1:0]   tx_write_pos, tx_write_pos_next;
  logic [spb_pkg::TX_PW-1:0]   tx_remaining, tx_remaining_next;

  spb_pkg::cmd_t              cmd;
  logic [spb_pkg::BYTE_W-1:0] data;
  logic                       message_start;

  logic                        ring_we;
  logic [spb_pkg::ENTRY_W-1:0] ring_wdata;
  logic                        tx_we;
  logic [spb_pkg::TX_AW-1:0]   tx_waddr;

  logic                       res_tx_valid, res_rd_valid, res_rd_end, res_dropped;
  logic [spb_pkg::BYTE_W-1:0] res_tx_data, res_rd_data;

  logic                        out_valid;
  logic                        out_tx_valid, out_rd_valid, out_rd_end, out_dropped;
  logic [spb_pkg::BYTE_W-1:0]  out_tx_data, out_rd_data;
  logic [spb_pkg::COUNT_W-1:0] out_packets, out_used;

  logic out_free, req_fire, exec;

  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign req_fire = req.valid && req.ready;
  assign exec = (state == S_EXEC) && out_free;

  function automatic logic [spb_pkg::RX_AW-1:0] ring_next(
    input logic [spb_pkg::RX_AW-1:0] p
  );
    return (p == spb_pkg::RX_AW'(spb_pkg::RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (req_fire) state <= S_EXEC;
        S_EXEC: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd           <= spb_pkg::cmd_t'(req.command);
      data          <= req.data;
      message_start <= req.message_start;
    end
  end

  always_ff @(posedge clk) begin
    ring_rdata <= rx_ring[rx_read_ptr];
    tx_rdata   <= tx_store[tx_read_pos[spb_pkg::TX_AW-1:0]];
    if (ring_we) rx_ring[rx_write_ptr] <= ring_wdata;
    if (tx_we) tx_store[tx_waddr] <= data;
  end

  always_comb begin
    rx_write_ptr_next = rx_write_ptr;
    rx_read_ptr_next  = rx_read_ptr;
    rx_fill_next      = rx_fill;
    packet_count_next = packet_count;
    tx_read_pos_next  = tx_read_pos;
    tx_write_pos_next = tx_write_pos;
    tx_remaining_next = tx_remaining;
    ring_we      = 1'b0;
    ring_wdata   = {1'b0, data};
    tx_we        = 1'b0;
    tx_waddr     = tx_write_pos[spb_pkg::TX_AW-1:0];
    res_tx_valid = 1'b0;
    res_tx_data  = '0;
    res_rd_valid = 1'b0;
    res_rd_data  = '0;
    res_rd_end   = 1'b0;
    res_dropped  = 1'b0;
    if (exec) begin
      unique case (cmd)
        spb_pkg::CMD_RX_BYTE: begin
          if (rx_fill < spb_pkg::FILL_W'(spb_pkg::RX_DEPTH - 1)) begin
            ring_we           = 1'b1;
            rx_write_ptr_next = ring_next(rx_write_ptr);
            rx_fill_next      = rx_fill + 1'b1;
          end else begin
            res_dropped = 1'b1;
          end
          if (tx_remaining != '0 && tx_read_pos < spb_pkg::TX_PW'(spb_pkg::TX_DEPTH)) begin
            res_tx_valid      = 1'b1;
            res_tx_data       = tx_rdata;
            tx_read_pos_next  = tx_read_pos + 1'b1;
            tx_remaining_next = tx_remaining - 1'b1;
          end
        end
        spb_pkg::CMD_CS_RELEASE: begin
          ring_wdata = spb_pkg::END_MARK;
          if (rx_fill < spb_pkg::FILL_W'(spb_pkg::RX_DEPTH)) begin
            ring_we           = 1'b1;
            rx_write_ptr_next = ring_next(rx_write_ptr);
            rx_fill_next      = rx_fill + 1'b1;
          end else begin
            res_dropped = 1'b1;
          end
          if (packet_count < spb_pkg::COUNT_MAX) packet_count_next = packet_count + 1'b1;
        end
        spb_pkg::CMD_HOST_POP: begin
          if (packet_count != '0) begin
            res_rd_valid = 1'b1;
            if (rx_fill == '0) begin
              res_rd_end        = 1'b1;
              packet_count_next = packet_count - 1'b1;
            end else begin
              rx_read_ptr_next = ring_next(rx_read_ptr);
              rx_fill_next     = rx_fill - 1'b1;
              if (ring_rdata[spb_pkg::ENTRY_W-1]) begin
                res_rd_end        = 1'b1;
                packet_count_next = packet_count - 1'b1;
              end else begin
                res_rd_data = ring_rdata[spb_pkg::BYTE_W-1:0];
              end
            end
          end
        end
        spb_pkg::CMD_HOST_TX: begin
          if (message_start) begin
            tx_we             = 1'b1;
            tx_waddr          = '0;
            tx_read_pos_next  = spb_pkg::TX_PW'(1);
            tx_write_pos_next = spb_pkg::TX_PW'(1);
            tx_remaining_next = '0;
            res_tx_valid      = 1'b1;
            res_tx_data       = data;
          end else if (tx_write_pos < spb_pkg::TX_PW'(spb_pkg::TX_DEPTH)) begin
            tx_we             = 1'b1;
            tx_write_pos_next = tx_write_pos + 1'b1;
            tx_remaining_next = tx_remaining + 1'b1;
          end else begin
            res_dropped = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_write_ptr <= '0;
      rx_read_ptr  <= '0;
      rx_fill      <= '0;
      packet_count <= '0;
      tx_read_pos  <= '0;
      tx_write_pos <= '0;
      tx_remaining <= '0;
    end else begin
      rx_write_ptr <= rx_write_ptr_next;
      rx_read_ptr  <= rx_read_ptr_next;
      rx_fill      <= rx_fill_next;
      packet_count <= packet_count_next;
      tx_read_pos  <= tx_read_pos_next;
      tx_write_pos <= tx_write_pos_next;
      tx_remaining <= tx_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_tx_valid <= res_tx_valid;
      out_tx_data  <= res_tx_data;
      out_rd_valid <= res_rd_valid;
      out_rd_data  <= res_rd_data;
      out_rd_end   <= res_rd_end;
      out_dropped  <= res_dropped;
      out_packets  <= packet_count_next;
      out_used     <= spb_pkg::COUNT_W'(rx_fill_next);
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.tx_valid        = out_tx_valid;
  assign rsp.tx_data         = out_tx_data;
  assign rsp.rd_valid        = out_rd_valid;
  assign rsp.rd_data         = out_rd_data;
  assign rsp.rd_end          = out_rd_end;
  assign rsp.dropped         = out_dropped;
  assign rsp.packets_pending = out_packets;
  assign rsp.ring_used       = out_used;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    rx_fill <= spb_pkg::FILL_W'(spb_pkg::RX_DEPTH))
    else $error("ring fill above depth");

  a_ptr_fill: assert property (@(posedge clk) disable iff (rst)
    (rx_fill == '0 || rx_fill == spb_pkg::FILL_W'(spb_pkg::RX_DEPTH))
      == (rx_write_ptr == rx_read_ptr))
    else $error("ring pointers disagree with fill");

  a_tx_bound: assert property (@(posedge clk) disable iff (rst)
    tx_read_pos + tx_remaining == tx_write_pos || tx_remaining == '0)
    else $error("transmit queue positions inconsistent");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> state == S_EXEC)
    else $error("accepted request not executed");

endmodule
